### src/swbe_pkg.sv
// Shared constants for the border-extending sample window.
// No dependencies; imported by the top level and the testbench.
package swbe_pkg;
    localparam int MAX_SAMPLES = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int LEN_W       = ADDR_W + 1;
    localparam int POS_W       = 17;
    localparam int DIV_STAGES  = POS_W;
    localparam int PADDR_W     = 3;

    localparam logic [1:0] MODE_PERIODIC = 2'd0;
    localparam logic [1:0] MODE_MIRROR   = 2'd1;
    localparam logic [1:0] MODE_EDGE     = 2'd2;
    localparam logic [1:0] MODE_ZERO     = 2'd3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic REG_LENGTH = 1'b0;
    localparam logic REG_MODE   = 1'b1;
endpackage

### src/swbe_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module swbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule

### src/signal_window_border_extend.sv
// Border-extending sample window: o_valid follows start through capture, remainder and result stages.
// Throughput one word per cycle; o_busy is always low and the receiver cannot stall.
// The position passes a 17-stage restoring remainder pipeline, one quotient bit a stage.
// Loads travel the same pipeline so store writes and reads keep word order.
// Synchronous active-low reset clears the pipeline valid bits and registers
// (length 4096, periodic mode); the sample store is undefined until written.
module signal_window_border_extend (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic                                  i_cmd,
    input  logic [swbe_pkg::ADDR_W-1:0]           i_load_addr,
    input  logic signed [swbe_pkg::SAMPLE_BITS-1:0] i_load_re,
    input  logic signed [swbe_pkg::SAMPLE_BITS-1:0] i_load_im,
    input  logic signed [swbe_pkg::POS_W-1:0]     i_position,
    input  logic                                  i_last_of_part,
    output logic                                  o_valid,
    output logic signed [swbe_pkg::SAMPLE_BITS-1:0] o_value_re,
    output logic signed [swbe_pkg::SAMPLE_BITS-1:0] o_value_im,
    output logic                                  o_range_error,
    output logic                                  o_last,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [swbe_pkg::PADDR_W-1:0]          paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import swbe_pkg::*;

    localparam int DW = LEN_W + 1;   // divisor width (up to twice the length)
    localparam int SW = POS_W + DW;  // width of a shifted divisor

    typedef struct packed {
        logic                   valid;
        logic                   cmd;
        logic [ADDR_W-1:0]      addr;
        logic [SAMPLE_BITS-1:0] re;
        logic [SAMPLE_BITS-1:0] im;
        logic                   last;
        logic [POS_W-1:0]       pos;   // raw two's complement position
        logic [POS_W-1:0]       rem;   // magnitude, reduced stage by stage
    } t_pipe;

    // configuration registers
    logic [LEN_W-1:0] r_length;
    logic [1:0]       r_mode;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= LEN_W'(MAX_SAMPLES);
            r_mode   <= MODE_PERIODIC;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_LENGTH: r_length <= pwdata[LEN_W-1:0];
                REG_MODE:   r_mode   <= pwdata[1:0];
                default:    r_mode   <= r_mode;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_LENGTH: prdata = 32'(r_length);
            REG_MODE:   prdata = 32'(r_mode);
            default:    prdata = '0;
        endcase
    end

    // effective length: clamp into 1 .. MAX_SAMPLES
    logic [LEN_W-1:0] len;
    logic [DW-1:0]    div;
    always_comb begin
        priority if (r_length == '0)
            len = LEN_W'(1);
        else if (r_length > LEN_W'(MAX_SAMPLES))
            len = LEN_W'(MAX_SAMPLES);
        else
            len = r_length;
        // mirror on the right repeats with period 2L, everything else with L
        div = (r_mode == MODE_MIRROR) ? {len, 1'b0} : {1'b0, len};
    end

    assign o_busy = 1'b0;

    // remainder pipeline: stage 0 captures, stages 1..DIV_STAGES reduce
    t_pipe r_pipe [DIV_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe[0].valid <= 1'b0;
        end else begin
            r_pipe[0].valid <= i_start;
        end
        r_pipe[0].cmd  <= i_cmd;
        r_pipe[0].addr <= i_load_addr;
        r_pipe[0].re   <= i_load_re;
        r_pipe[0].im   <= i_load_im;
        r_pipe[0].last <= i_last_of_part;
        r_pipe[0].pos  <= i_position;
        r_pipe[0].rem  <= i_position[POS_W-1] ? (~i_position + POS_W'(1)) : i_position;
    end

    for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
        logic [SW-1:0]    shifted;
        logic [POS_W-1:0] n_rem;
        always_comb begin
            shifted = SW'(div) << (DIV_STAGES - s);
            if (SW'(r_pipe[s-1].rem) >= shifted)
                n_rem = r_pipe[s-1].rem - shifted[POS_W-1:0];
            else
                n_rem = r_pipe[s-1].rem;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pipe[s].valid <= 1'b0;
            end else begin
                r_pipe[s].valid <= r_pipe[s-1].valid;
            end
            r_pipe[s].cmd  <= r_pipe[s-1].cmd;
            r_pipe[s].addr <= r_pipe[s-1].addr;
            r_pipe[s].re   <= r_pipe[s-1].re;
            r_pipe[s].im   <= r_pipe[s-1].im;
            r_pipe[s].last <= r_pipe[s-1].last;
            r_pipe[s].pos  <= r_pipe[s-1].pos;
            r_pipe[s].rem  <= n_rem;
        end
    end

    // map the position to a store index under the border mode
    t_pipe           tail;
    logic            neg;
    logic [POS_W-1:0] mag;
    logic [DW-1:0]   rem_d;
    logic [DW-1:0]   len_d;
    logic [DW-1:0]   idx;
    logic            hit;
    logic            err;
    logic            in_sig;

    assign tail = r_pipe[DIV_STAGES];

    always_comb begin
        neg    = tail.pos[POS_W-1];
        mag    = ~tail.pos + POS_W'(1);
        rem_d  = tail.rem[DW-1:0];
        len_d  = DW'(len);
        in_sig = !neg && (tail.pos < POS_W'(len));
        idx    = tail.pos[DW-1:0];
        hit    = 1'b1;
        err    = 1'b0;
        if (!in_sig) begin
            unique case (r_mode)
                MODE_PERIODIC: begin
                    if (neg && rem_d != '0)
                        idx = len_d - rem_d;
                    else
                        idx = rem_d;
                end
                MODE_MIRROR: begin
                    // the left reflection uses the full magnitude, not the reduced one
                    if (neg) begin
                        if (mag < POS_W'(len)) begin
                            idx = mag[DW-1:0];
                        end else begin
                            hit = 1'b0;
                            err = 1'b1;
                        end
                    end else if (rem_d < len_d) begin
                        idx = rem_d;
                    end else begin
                        idx = {len, 1'b0} - DW'(1) - rem_d;
                    end
                end
                MODE_EDGE: idx = neg ? '0 : len_d - DW'(1);
                MODE_ZERO: hit = 1'b0;
                default:   hit = 1'b0;
            endcase
        end
    end

    // at most one store access per word: write for loads, read for reads that hit
    logic                     ram_en;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_addr;
    logic [2*SAMPLE_BITS-1:0] ram_rdata;

    assign ram_en   = tail.valid && (tail.cmd == CMD_LOAD || hit);
    assign ram_we   = (tail.cmd == CMD_LOAD);
    assign ram_addr = ram_we ? tail.addr : idx[ADDR_W-1:0];

    swbe_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata ({tail.re, tail.im}),
        .o_rdata (ram_rdata)
    );

    // result stage: hold flags alongside the registered read data
    logic r_valid;
    logic r_hit;
    logic r_err;
    logic r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= tail.valid && (tail.cmd == CMD_READ);
        end
        r_hit  <= hit;
        r_err  <= err;
        r_last <= tail.last;
    end

    assign o_valid       = r_valid;
    assign o_value_re    = r_hit ? ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
    assign o_value_im    = r_hit ? ram_rdata[SAMPLE_BITS-1:0] : '0;
    assign o_range_error = r_err;
    assign o_last        = r_last;
endmodule

### tb/signal_window_border_extend_tb.sv
// Self-checking testbench for signal_window_border_extend: sample loads and
// border-extended reads under every border mode and several signal lengths.
// Depends on swbe_pkg and the signal_window_border_extend top level only.
module signal_window_border_extend_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import swbe_pkg::*;

    localparam int PIPE_LAT  = 19;
    localparam int SETTLE    = PIPE_LAT + 6;
    localparam int STALL_MAX = 600;

    typedef struct {
        logic                          cmd;
        logic [ADDR_W-1:0]             addr;
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
        logic signed [POS_W-1:0]       pos;
        logic                          last;
    } t_word;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
        logic                          err;
        logic                          last;
    } t_sample;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic o_busy;
    logic i_cmd = CMD_LOAD;
    logic [ADDR_W-1:0] i_load_addr = '0;
    logic signed [SAMPLE_BITS-1:0] i_load_re = '0;
    logic signed [SAMPLE_BITS-1:0] i_load_im = '0;
    logic signed [POS_W-1:0] i_position = '0;
    logic i_last_of_part = 1'b0;
    logic o_valid;
    logic signed [SAMPLE_BITS-1:0] o_value_re;
    logic signed [SAMPLE_BITS-1:0] o_value_im;
    logic o_range_error;
    logic o_last;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    signal_window_border_extend dut (.*);

    always #5 i_clk = ~i_clk;

    // Shared shadow of the registers; only changed while the block is idle.
    int unsigned cfg_len = MAX_SAMPLES;
    logic [1:0]  cfg_mode = MODE_PERIODIC;

    logic [SAMPLE_BITS-1:0] shadow_re [MAX_SAMPLES];
    logic [SAMPLE_BITS-1:0] shadow_im [MAX_SAMPLES];
    bit                     loaded [MAX_SAMPLES];   // as seen by the stimulus

    t_word   pending_words [$];
    t_sample window_expect [$];
    bit      failed = 1'b0;
    int      gap = 0;
    int      idle_cycles = 0;

    function automatic int eff_len(int unsigned raw);
        if (raw < 1) return 1;
        if (raw > MAX_SAMPLES) return MAX_SAMPLES;
        return int'(raw);
    endfunction

    function automatic int wrap(int p, int m);
        int r;
        r = p % m;
        if (r < 0) r += m;
        return r;
    endfunction

    // Store index behind a position; -1 means zero output, -2 left mirror overflow.
    function automatic int border_index(int p);
        int n, q;
        n = eff_len(cfg_len);
        if (p >= 0 && p < n) return p;
        case (cfg_mode)
            MODE_PERIODIC: return wrap(p, n);
            MODE_MIRROR: begin
                if (p < 0) return (-p <= n - 1) ? -p : -2;
                q = wrap(p, 2 * n);
                return (q < n) ? q : 2 * n - 1 - q;
            end
            MODE_EDGE: return (p < 0) ? 0 : n - 1;
            default: return -1;
        endcase
    endfunction

    // Driver: hold a word until accepted, then predict it and advance.
    always @(posedge i_clk) begin
        t_word w;
        t_sample s;
        int k;
        if (i_rst_n && i_start && !o_busy) begin
            if (i_cmd == CMD_LOAD) begin
                shadow_re[i_load_addr] = i_load_re;
                shadow_im[i_load_addr] = i_load_im;
            end else begin
                k = border_index(i_position);
                s.re = (k >= 0) ? shadow_re[ADDR_W'(k)] : '0;
                s.im = (k >= 0) ? shadow_im[ADDR_W'(k)] : '0;
                s.err = (k == -2);
                s.last = i_last_of_part;
                window_expect.push_back(s);
            end
        end
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (i_start && o_busy) begin
            i_start <= 1'b1;
        end else if (gap > 0) begin
            gap = gap - 1;
            i_start <= 1'b0;
        end else if (pending_words.size() > 0) begin
            w = pending_words.pop_front();
            i_cmd <= w.cmd;
            i_load_addr <= w.addr;
            i_load_re <= w.re;
            i_load_im <= w.im;
            i_position <= w.pos;
            i_last_of_part <= w.last;
            i_start <= 1'b1;
            // mostly back-to-back, with bursts of random gaps
            gap = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 19)) : 0;
        end else begin
            i_start <= 1'b0;
        end
    end

    // Monitor: compare each result word with the oldest expectation.
    always @(posedge i_clk) begin
        t_sample s;
        if (i_rst_n && o_valid) begin
            if (window_expect.size() == 0) begin
                $display("%0t: unexpected result re=%0d im=%0d err=%0b last=%0b", $time,
                         o_value_re, o_value_im, o_range_error, o_last);
                failed = 1'b1;
            end else begin
                s = window_expect.pop_front();
                if (o_value_re !== s.re) begin
                    $display("%0t: value_re expected %0d got %0d", $time, s.re, o_value_re);
                    failed = 1'b1;
                end
                if (o_value_im !== s.im) begin
                    $display("%0t: value_im expected %0d got %0d", $time, s.im, o_value_im);
                    failed = 1'b1;
                end
                if (o_range_error !== s.err) begin
                    $display("%0t: range_error expected %0b got %0b", $time, s.err,
                             o_range_error);
                    failed = 1'b1;
                end
                if (o_last !== s.last) begin
                    $display("%0t: last expected %0b got %0b", $time, s.last, o_last);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_MAX) begin
            $display("signal_window_border_extend test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_load(int a, logic [15:0] re, logic [15:0] im);
        t_word w;
        w.cmd = CMD_LOAD;
        w.addr = ADDR_W'(a);
        w.re = re;
        w.im = im;
        w.pos = POS_W'($urandom_range(0, 131071));   // ignored by loads
        w.last = 1'($urandom_range(0, 1));
        loaded[ADDR_W'(a)] = 1'b1;
        pending_words.push_back(w);
    endtask

    // Queue a read, loading its store entry first if it was never written.
    task automatic add_read(int p, bit last);
        t_word w;
        int k;
        k = border_index(p);
        if (k >= 0 && !loaded[ADDR_W'(k)]) add_load(k, 16'($urandom), 16'($urandom));
        w.cmd = CMD_READ;
        w.addr = ADDR_W'($urandom);                    // ignored by reads
        w.re = 16'($urandom);
        w.im = 16'($urandom);
        w.pos = POS_W'(p);
        w.last = last;
        pending_words.push_back(w);
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || i_start || window_expect.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] a, logic [31:0] d);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Reconfigure only once the pipeline is empty.
    task automatic configure(int unsigned len, logic [1:0] mode);
        drain();
        apb_write(PADDR_W'(4 * REG_LENGTH), len);
        apb_write(PADDR_W'(4 * REG_MODE), 32'(mode));
        cfg_len = len;
        cfg_mode = mode;
    endtask

    task automatic random_window(int count);
        int n, p;
        n = eff_len(cfg_len);
        for (int j = 0; j < count; j++) begin
            case ($urandom_range(0, 9))
                0: add_load($urandom_range(0, MAX_SAMPLES - 1), 16'($urandom), 16'($urandom));
                1: add_read($signed(17'($urandom_range(0, 131071))),
                            1'($urandom_range(0, 1)));
                default: begin
                    p = $urandom_range(0, 5 * n + 2);
                    add_read(p - 2 * n - 1, (j % 8) == 7);
                end
            endcase
        end
    endtask

    initial begin
        int unsigned lens [14] = '{1, 4096, 0, 8191, 2, 3, 5, 7, 16, 31, 100, 1000, 4095, 13};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes under reset settings, then every border mode.
        add_load(0, 16'h7FFF, 16'h8000);
        add_load(MAX_SAMPLES - 1, 16'h8000, 16'h7FFF);
        add_load(1, 16'hFFFF, 16'h0000);
        add_read(0, 1'b0);
        add_read(MAX_SAMPLES - 1, 1'b0);
        add_read(-1, 1'b0);
        add_read(MAX_SAMPLES, 1'b0);
        add_read(-65536, 1'b0);
        add_read(65535, 1'b1);
        for (int m = 0; m < 4; m++) begin
            configure(4, m[1:0]);
            add_load(2, 16'h1234, 16'hABCD);
            add_load(3, 16'h5555, 16'hAAAA);
            add_read(-3, 1'b0);
            add_read(-4, 1'b0);           // just past the left reflection
            add_read(5, 1'b0);
            add_read(7, 1'b0);
            add_read(-65536, 1'b1);
        end

        // Random phases over lengths and modes, extremes among them.
        for (int ph = 0; ph < 28; ph++) begin
            configure(lens[ph % 14], 2'((ph / 14) * 2 + ph[0]) ^ 2'(ph % 4));
            random_window(24);
        end

        drain();
        if (failed) begin
            $display("signal_window_border_extend test failed");
        end else begin
            $display("signal_window_border_extend test passed");
        end
        $finish;
    end
endmodule

### filelist.f
src/swbe_pkg.sv
src/swbe_ram.sv
src/signal_window_border_extend.sv
tb/signal_window_border_extend_tb.sv
